// File: rtl/stride_scheduler_select_macros.svh
// Assertion macros for the stride scheduler block.
// Used by the top level only; empty when SYNTHESIS is defined.
`ifndef STRIDE_SCHEDULER_SELECT_MACROS_SVH
`define STRIDE_SCHEDULER_SELECT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SSEL_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stride scheduler assertion failed");
// next-cycle implication
`define SSEL_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stride scheduler assertion failed");
`else
`define SSEL_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define SSEL_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: rtl/ssel_pkg.sv
// Shared constants, widths and saturating helpers for the stride scheduler.
// No dependencies; imported by ssel_div and stride_scheduler_select.
package ssel_pkg;

   localparam int MAX_CLIENTS      = 8;
   localparam int STRIDE_FRAC_BITS = 16;
   localparam int NUM_REGS         = 8;
   localparam int STRIDE_BASE      = 10000;

   localparam int TICKET_W = 16;
   localparam int PASS_W   = 64;
   localparam int STRIDE_W = 30;
   localparam int GRANT_W  = 32;
   localparam int WINNER_W = 3;

   localparam int CLI_W      = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
   localparam int REG_IDX_W  = $clog2(NUM_REGS);
   localparam int CSR_ADDR_W = REG_IDX_W + 2;
   localparam int CSR_DATA_W = 32;

   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = ((WINNER_W + GRANT_W + 7) / 8) * 8;

   // dividend of the stride division: base scaled to fixed point
   localparam int NUMER_W = $clog2(STRIDE_BASE + 1) + STRIDE_FRAC_BITS;
   localparam logic [NUMER_W-1:0] NUMER = NUMER_W'(STRIDE_BASE) << STRIDE_FRAC_BITS;
   localparam int QX_W = (NUMER_W > STRIDE_W) ? NUMER_W : STRIDE_W;
   localparam logic [STRIDE_W-1:0] STRIDE_MAX = '1;

   function automatic logic [STRIDE_W-1:0] sat_stride(input logic [NUMER_W-1:0] q);
      logic [QX_W-1:0] qx;
      qx = QX_W'(q);
      if (qx > QX_W'(STRIDE_MAX)) return STRIDE_MAX;
      return STRIDE_W'(qx);
   endfunction

   function automatic logic [PASS_W-1:0] sat_pass_add(input logic [PASS_W-1:0] p,
                                                      input logic [STRIDE_W-1:0] s);
      logic [PASS_W:0] sum;
      sum = {1'b0, p} + (PASS_W+1)'(s);
      if (sum[PASS_W]) return '1;
      return sum[PASS_W-1:0];
   endfunction

   function automatic logic [GRANT_W-1:0] sat_inc(input logic [GRANT_W-1:0] g);
      if (g == '1) return g;
      return g + GRANT_W'(1);
   endfunction

endpackage

// File: rtl/ssel_div.sv
// Restoring divider, one quotient bit per cycle: NUMER / divisor.
// Depends on ssel_pkg for the fixed dividend and widths.
module ssel_div
   import ssel_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [TICKET_W-1:0] divisor,
   output logic                done,
   output logic [NUMER_W-1:0]  quotient
);

   localparam int CNT_W = $clog2(NUMER_W + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [TICKET_W-1:0] rem_ff, rem_in;
   logic [TICKET_W-1:0] div_ff, div_in;
   logic [NUMER_W-1:0]  num_ff, num_in;
   logic [NUMER_W-1:0]  quo_ff, quo_in;
   logic [TICKET_W:0]   trial;
   logic [TICKET_W:0]   diff;

   assign trial = {rem_ff, num_ff[NUMER_W-1]};
   assign diff  = trial - {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUMER_W);
         rem_in  = '0;
         div_in  = divisor;
         num_in  = NUMER;
         quo_in  = '0;
      end else if (busy_ff) begin
         num_in = num_ff << 1;
         if (trial >= {1'b0, div_ff}) begin
            rem_in = diff[TICKET_W-1:0];
            quo_in = {quo_ff[NUMER_W-2:0], 1'b1};
         end else begin
            rem_in = trial[TICKET_W-1:0];
            quo_in = {quo_ff[NUMER_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      div_ff <= div_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: rtl/stride_scheduler_select.sv
// Stride scheduler select: one grant decision per request.
// Plain tick: request accept, pass scan over all clients, then the update step that sets rsp_tvalid.
// Restart (or first tick after reset): the bit-serial stride divider is first run once
// per client, before the pass scan.
// One request at a time; req_tready rises with rsp_tvalid.
// A result not yet taken holds the next request in its update step.
// Synchronous active-high reset clears control state and ticket registers.
`include "stride_scheduler_select_macros.svh"

module stride_scheduler_select
   import ssel_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [0] restart, rest zero
   // result channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [2:0] winner, [34:3] winner_grants, pad
   output logic                   rsp_tuser,   // [0] none_active
   // configuration
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_SCAN,
      ST_UPDATE
   } state_type;

   localparam logic [CLI_W-1:0] LAST_CLI = CLI_W'(MAX_CLIENTS - 1);

   // ticket registers
   logic [TICKET_W-1:0] tickets_ff [NUM_REGS];
   logic [TICKET_W-1:0] tick_cli [MAX_CLIENTS];
   logic                csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = CSR_DATA_W'(tickets_ff[csr_paddr[CSR_ADDR_W-1:2]]);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) tickets_ff[i] <= '0;
      end else if (csr_wr) begin
         tickets_ff[csr_paddr[CSR_ADDR_W-1:2]] <= csr_pwdata[TICKET_W-1:0];
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_CLIENTS; i++) tick_cli[i] = tickets_ff[i];
   end

   // per-client state, read only at the scan index
   logic [PASS_W-1:0]   pass_ff   [MAX_CLIENTS];
   logic [STRIDE_W-1:0] stride_ff [MAX_CLIENTS];
   logic [GRANT_W-1:0]  grant_ff  [MAX_CLIENTS];

   logic                pass_we, stride_we, grant_we;
   logic [CLI_W-1:0]    wr_idx;
   logic [PASS_W-1:0]   pass_in;
   logic [STRIDE_W-1:0] stride_in;
   logic [GRANT_W-1:0]  grant_in;

   always_ff @(posedge clock) begin
      if (pass_we)   pass_ff[wr_idx]   <= pass_in;
      if (stride_we) stride_ff[wr_idx] <= stride_in;
      if (grant_we)  grant_ff[wr_idx]  <= grant_in;
   end

   // sequencer
   state_type           state_ff, state_in;
   logic                started_ff, started_in;
   logic [CLI_W-1:0]    idx_ff, idx_in;
   logic                found_ff, found_in;
   logic [CLI_W-1:0]    best_idx_ff, best_idx_in;
   logic [PASS_W-1:0]   best_pass_ff, best_pass_in;
   logic [STRIDE_W-1:0] best_stride_ff, best_stride_in;
   logic [GRANT_W-1:0]  best_grant_ff, best_grant_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [WINNER_W-1:0] rsp_winner_ff, rsp_winner_in;
   logic                rsp_none_ff, rsp_none_in;
   logic [GRANT_W-1:0]  rsp_grants_ff, rsp_grants_in;
   logic                req_acc;
   logic                take;
   logic [GRANT_W-1:0]  new_grant;

   // divider
   logic               div_start;
   logic               div_done;
   logic [NUMER_W-1:0] div_quo;

   ssel_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (tick_cli[idx_ff]),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   // pass compare: the shared unit during the scan
   assign take       = (tick_cli[idx_ff] != '0) &&
                       (!found_ff || (pass_ff[idx_ff] < best_pass_ff));
   assign new_grant  = sat_inc(best_grant_ff);

   always_comb begin
      state_in       = state_ff;
      started_in     = started_ff;
      idx_in         = idx_ff;
      found_in       = found_ff;
      best_idx_in    = best_idx_ff;
      best_pass_in   = best_pass_ff;
      best_stride_in = best_stride_ff;
      best_grant_in  = best_grant_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_winner_in  = rsp_winner_ff;
      rsp_none_in    = rsp_none_ff;
      rsp_grants_in  = rsp_grants_ff;
      div_start      = 1'b0;
      pass_we        = 1'b0;
      stride_we      = 1'b0;
      grant_we       = 1'b0;
      wr_idx         = idx_ff;
      pass_in        = '0;
      stride_in      = '0;
      grant_in       = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               idx_in   = '0;
               found_in = 1'b0;
               if (req_tdata[0] || !started_ff) state_in = ST_DIV_GO;
               else                             state_in = ST_SCAN;
            end
         end
         ST_DIV_GO: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               stride_we = 1'b1;
               pass_we   = 1'b1;
               grant_we  = 1'b1;
               stride_in = (tick_cli[idx_ff] == '0) ? '0 : sat_stride(div_quo);
               if (idx_ff == LAST_CLI) begin
                  started_in = 1'b1;
                  idx_in     = '0;
                  state_in   = ST_SCAN;
               end else begin
                  idx_in   = idx_ff + CLI_W'(1);
                  state_in = ST_DIV_GO;
               end
            end
         end
         ST_SCAN: begin
            if (take) begin
               found_in       = 1'b1;
               best_idx_in    = idx_ff;
               best_pass_in   = pass_ff[idx_ff];
               best_stride_in = stride_ff[idx_ff];
               best_grant_in  = grant_ff[idx_ff];
            end
            if (idx_ff == LAST_CLI) state_in = ST_UPDATE;
            else                    idx_in   = idx_ff + CLI_W'(1);
         end
         ST_UPDATE: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (found_ff) begin
                  rsp_winner_in = WINNER_W'(best_idx_ff);
                  rsp_none_in   = 1'b0;
                  rsp_grants_in = new_grant;
                  wr_idx        = best_idx_ff;
                  pass_we       = 1'b1;
                  grant_we      = 1'b1;
                  pass_in       = sat_pass_add(best_pass_ff, best_stride_ff);
                  grant_in      = new_grant;
               end else begin
                  rsp_winner_in = '0;
                  rsp_none_in   = 1'b1;
                  rsp_grants_in = '0;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         started_ff   <= 1'b0;
         idx_ff       <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         started_ff   <= started_in;
         idx_ff       <= idx_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      best_idx_ff    <= best_idx_in;
      best_pass_ff   <= best_pass_in;
      best_stride_ff <= best_stride_in;
      best_grant_ff  <= best_grant_in;
      rsp_winner_ff  <= rsp_winner_in;
      rsp_none_ff    <= rsp_none_in;
      rsp_grants_ff  <= rsp_grants_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'({rsp_grants_ff, rsp_winner_ff});
   assign rsp_tuser  = rsp_none_ff;

   // checks
   `SSEL_ASSERT_IMP(a_none_zero, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata == '0)
   `SSEL_ASSERT_IMP(a_grant_nonzero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_grants_ff != '0)
   `SSEL_ASSERT_NXT(a_busy_after_req, clock, reset, req_tvalid && req_tready, !req_tready)
   `SSEL_ASSERT_IMP(a_div_done_wait, clock, reset, state_ff != ST_DIV_WAIT, !div_done)

endmodule
